// File: sv/bhs_pkg.sv
// bhs_pkg: shared types and constants of the bucketed hash set.
// Used by every module under sv/ except bhs_ram; depends on nothing.
`timescale 1ns / 1ps

package bhs_pkg;

    localparam int KEY_W       = 32;
    localparam int DIV_W       = 7;   // width of table_size, so of the divisor and remainder
    localparam int BUCKETS_DEF = 64;
    localparam int WAYS_DEF    = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]        cmd;
        logic signed [31:0] key;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] bucket;
        logic [1:0] slot;
    } t_out_word;

    // one classified operation waiting for the table
    typedef struct packed {
        logic [1:0]       cmd;
        logic [KEY_W-1:0] key;
        logic [DIV_W-1:0] bucket;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// File: sv/bucketed_hash_set.sv
// bucketed_hash_set: set of signed 32-bit keys, BUCKETS rows of WAYS slots.
// Takes one word at a time: no new word is accepted until the one-bit-per-cycle
// remainder divider in the front has finished and its job is pushed.
// Reset is synchronous: after it the back sweeps all BUCKETS valid rows
// with o_in_ready low; configuration writes are taken throughout.
// Depends on bhs_pkg, bhs_front, bhs_fifo, bhs_back, bhs_ram.
`timescale 1ns / 1ps

module bucketed_hash_set #(
    parameter int BUCKETS = bhs_pkg::BUCKETS_DEF,
    parameter int WAYS    = bhs_pkg::WAYS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  bhs_pkg::t_in_word          i_in_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output bhs_pkg::t_out_word         o_out_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bhs_pkg::DIV_W-1:0]  i_cfg_data
);

    logic [bhs_pkg::DIV_W-1:0] r_table_size;
    bhs_pkg::t_back_stat       back_stat;
    bhs_pkg::t_job             push_job, head;
    logic                      push, full, pop, empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= bhs_pkg::DIV_W'(64);
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data;
        end
    end

    bhs_front #(.BUCKETS(BUCKETS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_table_size (r_table_size),
        .i_back_stat  (back_stat),
        .o_push       (push),
        .o_push_job   (push_job),
        .i_full       (full)
    );

    bhs_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (empty)
    );

    bhs_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// File: sv/bhs_ram.sv
// bhs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bhs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bhs_front.sv
// bhs_front: accepts words, folds the key to its magnitude and finds the
// bucket with a bit-serial restoring divider. Depends on bhs_pkg.
`timescale 1ns / 1ps

module bhs_front #(
    parameter int BUCKETS = bhs_pkg::BUCKETS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bhs_pkg::t_in_word            i_in_word,
    input  logic [bhs_pkg::DIV_W-1:0]    i_table_size,
    input  bhs_pkg::t_back_stat          i_back_stat,
    output logic                         o_push,
    output bhs_pkg::t_job                o_push_job,
    input  logic                         i_full
);

    localparam int KW = bhs_pkg::KEY_W;
    localparam int DW = bhs_pkg::DIV_W;
    localparam int CW = $clog2(KW);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate         r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [KW-1:0]   r_dvd, n_dvd;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_div, n_div;
    logic [1:0]      r_cmd, n_cmd;
    logic [KW-1:0]   r_key, n_key;

    logic            accept;
    logic [DW-1:0]   eff;
    logic [KW-1:0]   mag;
    logic [DW:0]     trial;

    assign o_in_ready = (r_state == F_IDLE) && !i_back_stat.clearing;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        if (i_table_size == '0) begin
            eff = DW'(1);
        end else if (32'(i_table_size) > BUCKETS) begin
            eff = DW'(BUCKETS);
        end else begin
            eff = i_table_size;
        end
    end

    // the most negative key maps to 2^31 unsigned
    assign mag   = i_in_word.key[KW-1] ? (KW'(0) - KW'(i_in_word.key)) : KW'(i_in_word.key);
    assign trial = {r_rem, r_dvd[KW-1]};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_div   = r_div;
        n_cmd   = r_cmd;
        n_key   = r_key;
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_state = F_DIV;
                    n_cnt   = CW'(KW - 1);
                    n_dvd   = mag;
                    n_rem   = '0;
                    n_div   = eff;
                    n_cmd   = i_in_word.cmd;
                    n_key   = KW'(i_in_word.key);
                end
            end
            F_DIV: begin
                // remainder stays below the divisor, so trial < 2 * divisor
                if (trial >= {1'b0, r_div}) begin
                    n_rem = DW'(trial - {1'b0, r_div});
                end else begin
                    n_rem = DW'(trial);
                end
                n_dvd = {r_dvd[KW-2:0], 1'b0};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_div <= n_div;
        r_cmd <= n_cmd;
        r_key <= n_key;
    end

    assign o_push            = (r_state == F_PUSH) && !i_full;
    assign o_push_job.cmd    = r_cmd;
    assign o_push_job.key    = r_key;
    assign o_push_job.bucket = r_rem;

endmodule

// File: sv/bhs_fifo.sv
// bhs_fifo: short job queue between the front and the back.
// Depends on bhs_pkg for the job type and depth.
`timescale 1ns / 1ps

module bhs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bhs_pkg::t_job  i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output bhs_pkg::t_job  o_head,
    output logic           o_empty
);

    localparam int D  = bhs_pkg::QUEUE_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int NW = $clog2(D + 1);

    bhs_pkg::t_job r_q [D];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == NW'(D));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_q[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PW'(D - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(D - 1)) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_q[r_wp] <= i_push_job;
        end
    end

endmodule

// File: sv/bhs_back.sv
// bhs_back: clears the valid rows after reset, then pops jobs, reads the
// bucket row, matches keys and writes back. Depends on bhs_pkg, bhs_ram.
`timescale 1ns / 1ps

module bhs_back #(
    parameter int BUCKETS = bhs_pkg::BUCKETS_DEF,
    parameter int WAYS    = bhs_pkg::WAYS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bhs_pkg::t_job        i_head,
    input  logic                 i_empty,
    output logic                 o_pop,
    output bhs_pkg::t_back_stat  o_stat,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bhs_pkg::t_out_word   o_out_word
);

    localparam int KW = bhs_pkg::KEY_W;
    localparam int AW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_LOOK  = 3'b100
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    bhs_pkg::t_job       r_job, n_job;
    logic                r_out_valid, n_out_valid;
    bhs_pkg::t_out_word  r_out_word, n_out_word;

    logic [AW-1:0]       raddr, job_addr;
    logic [WAYS-1:0]     vrow, v_wdata;
    logic [WAYS*KW-1:0]  krow, k_wdata;
    logic                v_we, k_we;
    logic                go;
    logic                hit_found, free_found;
    logic [WW-1:0]       hit_way, free_way;
    logic                ins_new, del_hit;

    assign job_addr = AW'(r_job.bucket);
    assign raddr    = (r_state == B_IDLE) ? AW'(i_head.bucket) : job_addr;
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign go       = (r_state == B_LOOK) && (!r_out_valid || i_out_ready);
    assign o_stat.clearing = (r_state == B_CLEAR);

    bhs_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr ((r_state == B_CLEAR) ? r_clr : job_addr),
        .i_wdata (v_wdata),
        .i_raddr (raddr),
        .o_rdata (vrow)
    );

    bhs_ram #(.WIDTH(WAYS * KW), .DEPTH(BUCKETS)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr (job_addr),
        .i_wdata (k_wdata),
        .i_raddr (raddr),
        .o_rdata (krow)
    );

    // lowest matching way and lowest free way
    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (vrow[w]) begin
                if (!hit_found && (krow[w*KW +: KW] == r_job.key)) begin
                    hit_found = 1'b1;
                    hit_way   = WW'(w);
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = WW'(w);
            end
        end
    end

    assign ins_new = (r_job.cmd == bhs_pkg::CMD_INSERT) && !hit_found && free_found;
    assign del_hit = (r_job.cmd == bhs_pkg::CMD_DELETE) && hit_found;

    always_comb begin
        v_wdata = vrow;
        k_wdata = krow;
        for (int w = 0; w < WAYS; w++) begin
            if (ins_new && (WW'(w) == free_way)) begin
                v_wdata[w]          = 1'b1;
                k_wdata[w*KW +: KW] = r_job.key;
            end
            if (del_hit && (WW'(w) == hit_way)) begin
                v_wdata[w] = 1'b0;
            end
        end
        if (r_state == B_CLEAR) begin
            v_wdata = '0;
        end
    end

    assign v_we = (r_state == B_CLEAR) || (go && (ins_new || del_hit));
    assign k_we = go && ins_new;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_job       = r_job;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(BUCKETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_empty) begin
                    n_job   = i_head;
                    n_state = B_LOOK;
                end
            end
            B_LOOK: begin
                if (go) begin
                    n_out_valid       = 1'b1;
                    n_out_word.bucket = 6'(r_job.bucket);
                    n_out_word.slot   = '0;
                    case (r_job.cmd)
                        bhs_pkg::CMD_INSERT: begin
                            if (hit_found) begin
                                n_out_word.status = bhs_pkg::ST_DUPLICATE;
                                n_out_word.slot   = 2'(hit_way);
                            end else if (free_found) begin
                                n_out_word.status = bhs_pkg::ST_DONE;
                                n_out_word.slot   = 2'(free_way);
                            end else begin
                                n_out_word.status = bhs_pkg::ST_FULL;
                            end
                        end
                        bhs_pkg::CMD_DELETE: begin
                            if (hit_found) begin
                                n_out_word.status = bhs_pkg::ST_DONE;
                                n_out_word.slot   = 2'(hit_way);
                            end else begin
                                n_out_word.status = bhs_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            // search, and the unused code behaves the same
                            if (hit_found) begin
                                n_out_word.status = bhs_pkg::ST_FOUND;
                                n_out_word.slot   = 2'(hit_way);
                            end else begin
                                n_out_word.status = bhs_pkg::ST_NOT_FOUND;
                            end
                        end
                    endcase
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_job      <= n_job;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
